FILE: sv/cqmf_pkg.sv
// shared constants, types and rom builder for the complex qmf analysis bank
package cqmf_pkg;

    localparam int SUBBANDS_DEF    = 64;
    localparam int TAPS_DEF        = 640;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int REQ_W      = 2;
    localparam int SAMPLE_W   = 24;
    localparam int COEF_BITS  = 24;
    localparam int HIST_AW    = 10;
    localparam int U_AW       = 7;
    localparam int ROM_AW     = 9;
    localparam int SUB_W      = 6;
    localparam int U_BITS     = 32;
    localparam int ROM_BITS   = 24;
    localparam int OP_BITS    = 32;
    localparam int PROD_BITS  = OP_BITS + ROM_BITS;
    localparam int ACC_BITS   = 64;
    localparam int OUT_BITS   = 40;
    localparam int OUT_SHIFT  = 22;

    localparam logic signed [ACC_BITS-1:0] OUT_MAX  = 64'sd549755813887;
    localparam logic signed [ACC_BITS-1:0] OUT_MIN  = -64'sd549755813888;
    localparam logic signed [ACC_BITS-1:0] OUT_HALF = 64'sd1 <<< (OUT_SHIFT - 1);

    localparam longint          Q30_ONE    = 64'sd1073741824;
    localparam longint unsigned PIHALF_Q30 = 64'd1686629713;

    localparam longint unsigned SinDiv [1:9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                  64'd156, 64'd210, 64'd272, 64'd342};
    localparam longint unsigned CosDiv [1:9] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                                  64'd132, 64'd182, 64'd240, 64'd306};

    typedef enum logic [REQ_W-1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_COEF   = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef struct packed {
        logic               hist_clr;
        logic [HIST_AW-1:0] clr_addr;
        logic               smp_wr;
        logic               coef_wr;
        logic               fold_rd;
        logic [HIST_AW-1:0] tap;
        logic [U_AW-1:0]    fold_n;
        logic               fold_zero;
        logic               mod_rd;
        logic [U_AW-1:0]    mod_n;
        logic [ROM_AW-1:0]  mod_m;
        logic               first;
        logic               last;
        logic [SUB_W-1:0]   k;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic res_full;
    } t_dp_sts;

    function automatic longint to_q22(input longint v);
        longint t;
        t = v;
        if (t < 0) t = 0;
        if (t > Q30_ONE) t = Q30_ONE;
        return (t + 64'sd128) >>> 8;
    endfunction

    // {cos, sin} in q2.22 for one phase fraction of a full turn
    function automatic logic [2*ROM_BITS-1:0] rom_entry(input longint unsigned p);
        longint unsigned r;
        longint unsigned x;
        longint unsigned ts;
        longint unsigned tc;
        longint          s;
        longint          c;
        longint          cv;
        longint          sv;
        logic [1:0]      quad;
        logic [ROM_BITS-1:0] co;
        logic [ROM_BITS-1:0] si;
        quad = p[31:30];
        r    = p & 64'h3FFF_FFFF;
        x    = (r * PIHALF_Q30) >> 30;
        s    = longint'(x);
        c    = Q30_ONE;
        ts   = x;
        tc   = 64'(Q30_ONE);
        for (int i = 1; i <= 9; i++) begin
            ts = ((((ts * x) >> 30) * x) >> 30) / SinDiv[i];
            tc = ((((tc * x) >> 30) * x) >> 30) / CosDiv[i];
            if (i % 2 == 1) begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end else begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
        cv = to_q22(c);
        sv = to_q22(s);
        unique case (quad)
            2'd0: begin co = ROM_BITS'(cv);  si = ROM_BITS'(sv);  end
            2'd1: begin co = ROM_BITS'(-sv); si = ROM_BITS'(cv);  end
            2'd2: begin co = ROM_BITS'(-cv); si = ROM_BITS'(-sv); end
            default: begin co = ROM_BITS'(sv); si = ROM_BITS'(-cv); end
        endcase
        return {co, si};
    endfunction

endpackage

FILE: sv/cqmf_if.sv
// request and result channel interfaces
interface cqmf_in_if;
    import cqmf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic [HIST_AW-1:0]         coef_index;
    logic signed [COEF_BITS-1:0] coef_value;
    modport source (output valid, req_type, sample, coef_index, coef_value, input ready);
    modport sink (input valid, req_type, sample, coef_index, coef_value, output ready);
endinterface

interface cqmf_out_if;
    import cqmf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [SUB_W-1:0]           subband;
    logic signed [OUT_BITS-1:0] real_part;
    logic signed [OUT_BITS-1:0] imag_part;
    logic                       last;
    modport source (output valid, subband, real_part, imag_part, last, input ready);
    modport sink (input valid, subband, real_part, imag_part, last, output ready);
endinterface

FILE: sv/complex_qmf_analysis_bank.sv
// top level of the complex qmf analysis bank
// Each transaction on i_req is a pcm sample, a window coefficient write or a history
// clear. The sample that completes a block of SUBBANDS samples starts a fold pass,
// then for each subband a modulation pass and a wait until the result is taken on
// o_res. Both passes are served by the single pair of multiply-accumulate units.
// After reset and after every clear the history memory is swept to zero, during
// which i_req is not ready. Results of one block leave in ascending subband order
// with last on the final one.
module complex_qmf_analysis_bank #(
    parameter int SUBBANDS    = cqmf_pkg::SUBBANDS_DEF,
    parameter int TAPS        = cqmf_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = cqmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cqmf_in_if.sink      i_req,
    cqmf_out_if.source   o_res
);
    import cqmf_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    cqmf_ctrl #(
        .SUBBANDS (SUBBANDS),
        .TAPS     (TAPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .o_ready    (i_req.ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    cqmf_dpath #(
        .SUBBANDS    (SUBBANDS),
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_sample     (i_req.sample),
        .i_coef_index (i_req.coef_index),
        .i_coef_value (i_req.coef_value),
        .i_res_ready  (o_res.ready),
        .o_res_valid  (o_res.valid),
        .o_subband    (o_res.subband),
        .o_real_part  (o_res.real_part),
        .o_imag_part  (o_res.imag_part),
        .o_last       (o_res.last)
    );

    a_last_on_top_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.last == (o_res.subband == SUB_W'(SUBBANDS - 1))))
        else $error("last flag does not match subband");

    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_res.valid))
        else $error("request taken while a result is pending");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("request ready during clearing sweep");

endmodule

FILE: sv/cqmf_ctrl.sv
// sequencer for history clearing, window fold and modulation passes
module cqmf_ctrl #(
    parameter int SUBBANDS = cqmf_pkg::SUBBANDS_DEF,
    parameter int TAPS     = cqmf_pkg::TAPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [cqmf_pkg::REQ_W-1:0]  i_req_type,
    output logic                        o_ready,
    output cqmf_pkg::t_dp_cmd           o_cmd,
    input  cqmf_pkg::t_dp_sts           i_sts
);
    import cqmf_pkg::*;

    localparam int NU        = 2 * SUBBANDS;
    localparam int FOLDS     = TAPS / NU;
    localparam int FOLD_ISS  = (FOLDS == 0) ? 1 : FOLDS;
    localparam bit FOLD_ZERO = (FOLDS == 0);
    localparam int ROM_SIZE  = 8 * SUBBANDS;
    localparam int TW        = $clog2(TAPS);
    localparam int NW        = $clog2(NU);
    localparam int MW        = $clog2(ROM_SIZE);
    localparam int KW        = $clog2(SUBBANDS);
    localparam int JW        = (FOLD_ISS > 1) ? $clog2(FOLD_ISS) : 1;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b000_0001,
        ST_IDLE   = 7'b000_0010,
        ST_FOLD   = 7'b000_0100,
        ST_FDRAIN = 7'b000_1000,
        ST_MOD    = 7'b001_0000,
        ST_MDRAIN = 7'b010_0000,
        ST_OUT    = 7'b100_0000
    } t_state;

    t_state          r_state, n_state;
    logic [KW-1:0]   r_pos, n_pos;
    logic [TW-1:0]   r_clr, n_clr;
    logic [NW-1:0]   r_n, n_n;
    logic [JW-1:0]   r_j, n_j;
    logic [TW-1:0]   r_t, n_t;
    logic [KW-1:0]   r_k, n_k;
    logic [MW-1:0]   r_m, n_m;
    logic            w_accept;
    logic [KW-1:0]   w_k_next;
    logic [KW+1:0]   w_step;
    logic [MW:0]     w_msum;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_k_next = r_k + KW'(1);
    assign w_step   = {r_k, 2'b10};
    assign w_msum   = (MW+1)'(r_m) + (MW+1)'(w_step);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_clr   = r_clr;
        n_n     = r_n;
        n_j     = r_j;
        n_t     = r_t;
        n_k     = r_k;
        n_m     = r_m;
        o_cmd   = '0;
        o_cmd.k = SUB_W'(r_k);
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.hist_clr = 1'b1;
                o_cmd.clr_addr = HIST_AW'(r_clr);
                if (r_clr == TW'(TAPS - 1)) begin
                    n_clr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + TW'(1);
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req_type)
                        REQ_SAMPLE: begin
                            o_cmd.smp_wr = 1'b1;
                            if (r_pos == KW'(SUBBANDS - 1)) begin
                                n_pos   = '0;
                                n_state = ST_FOLD;
                            end else begin
                                n_pos = r_pos + KW'(1);
                            end
                        end
                        REQ_COEF: o_cmd.coef_wr = 1'b1;
                        REQ_CLEAR: begin
                            n_pos   = '0;
                            n_clr   = '0;
                            n_state = ST_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FOLD: begin
                o_cmd.fold_rd   = 1'b1;
                o_cmd.tap       = HIST_AW'(r_t);
                o_cmd.fold_n    = U_AW'(r_n);
                o_cmd.fold_zero = FOLD_ZERO;
                o_cmd.first     = (r_j == '0);
                o_cmd.last      = (r_j == JW'(FOLD_ISS - 1));
                if (r_j == JW'(FOLD_ISS - 1)) begin
                    n_j = '0;
                    if (r_n == NW'(NU - 1)) begin
                        n_n     = '0;
                        n_t     = '0;
                        n_state = ST_FDRAIN;
                    end else begin
                        n_n = r_n + NW'(1);
                        n_t = FOLD_ZERO ? '0 : TW'(r_n) + TW'(1);
                    end
                end else begin
                    n_j = r_j + JW'(1);
                    n_t = r_t + TW'(NU);
                end
            end
            ST_FDRAIN: begin
                if (!i_sts.busy) n_state = ST_MOD;
            end
            ST_MOD: begin
                o_cmd.mod_rd = 1'b1;
                o_cmd.mod_n  = U_AW'(r_n);
                o_cmd.mod_m  = ROM_AW'(r_m);
                o_cmd.first  = (r_n == '0);
                o_cmd.last   = (r_n == NW'(NU - 1));
                n_m = (w_msum >= (MW+1)'(ROM_SIZE)) ? MW'(w_msum - (MW+1)'(ROM_SIZE))
                                                    : MW'(w_msum);
                if (r_n == NW'(NU - 1)) begin
                    n_n     = '0;
                    n_state = ST_MDRAIN;
                end else begin
                    n_n = r_n + NW'(1);
                end
            end
            ST_MDRAIN: begin
                n_m = r_m;
                if (!i_sts.busy) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_sts.res_full) begin
                    if (r_k == KW'(SUBBANDS - 1)) begin
                        n_k     = '0;
                        n_m     = MW'(ROM_SIZE - 1);
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = w_k_next;
                        n_m     = MW'(ROM_SIZE - 1) - MW'({w_k_next, 1'b0});
                        n_state = ST_MOD;
                    end
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // phase restarts for each subband, so m is reloaded at the end of each pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_pos   <= '0;
            r_clr   <= '0;
            r_n     <= '0;
            r_j     <= '0;
            r_t     <= '0;
            r_k     <= '0;
            r_m     <= MW'(ROM_SIZE - 1);
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_clr   <= n_clr;
            r_n     <= n_n;
            r_j     <= n_j;
            r_t     <= n_t;
            r_k     <= n_k;
            r_m     <= (r_state == ST_MOD && r_n == NW'(NU - 1)) ? r_m : n_m;
        end
    end

endmodule

FILE: sv/cqmf_dpath.sv
// history, window and partial-sum memories, cosine and sine rom and the shared mac pair
module cqmf_dpath #(
    parameter int SUBBANDS    = cqmf_pkg::SUBBANDS_DEF,
    parameter int TAPS        = cqmf_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = cqmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cqmf_pkg::t_dp_cmd                    i_cmd,
    output cqmf_pkg::t_dp_sts                    o_sts,
    input  logic signed [cqmf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [cqmf_pkg::HIST_AW-1:0]         i_coef_index,
    input  logic signed [cqmf_pkg::COEF_BITS-1:0] i_coef_value,
    input  logic                                 i_res_ready,
    output logic                                 o_res_valid,
    output logic [cqmf_pkg::SUB_W-1:0]           o_subband,
    output logic signed [cqmf_pkg::OUT_BITS-1:0] o_real_part,
    output logic signed [cqmf_pkg::OUT_BITS-1:0] o_imag_part,
    output logic                                 o_last
);
    import cqmf_pkg::*;

    localparam int NU       = 2 * SUBBANDS;
    localparam int ROM_SIZE = 8 * SUBBANDS;
    localparam int TW       = $clog2(TAPS);
    localparam int NW       = $clog2(NU);
    localparam int MW       = $clog2(ROM_SIZE);
    localparam logic signed [ACC_BITS-1:0] U_HALF = 64'sd1 <<< (SAMPLE_BITS - 3);

    function automatic logic [OUT_BITS-1:0] sat_out(input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] t;
        t = v;
        if (t > OUT_MAX) t = OUT_MAX;
        if (t < OUT_MIN) t = OUT_MIN;
        return OUT_BITS'(t);
    endfunction

    logic [SAMPLE_BITS-1:0]    r_hist [TAPS];
    logic [COEF_BITS-1:0]      r_win  [TAPS];
    logic [U_BITS-1:0]         r_u    [NU];
    logic [2*ROM_BITS-1:0]     w_rom  [ROM_SIZE];

    logic [TW-1:0]             r_wp, r_head;
    logic [TW:0]               w_diff;
    logic [TW-1:0]             w_phys;
    logic [31:0]               w_s32;

    logic [SAMPLE_BITS-1:0]    r_hist_q;
    logic [COEF_BITS-1:0]      r_win_q;
    logic [U_BITS-1:0]         r_u_q;
    logic [2*ROM_BITS-1:0]     r_rom_q;

    logic                      r1_v, r1_fold, r1_first, r1_last, r1_zero;
    logic [NW-1:0]             r1_n;
    logic                      r2_v, r2_fold, r2_first, r2_last;
    logic [NW-1:0]             r2_n;
    logic signed [PROD_BITS-1:0] r2_pa, r2_pb;
    logic                      r3_v, r3_fold, r3_last;
    logic [NW-1:0]             r3_n;
    logic signed [ACC_BITS-1:0] r_acc_a, r_acc_b;

    logic signed [OP_BITS-1:0]  w_op_a;
    logic signed [ROM_BITS-1:0] w_op_b;
    logic signed [PROD_BITS-1:0] w_pa, w_pb;
    logic signed [ACC_BITS-1:0] w_u_sh, w_re_sh, w_im_sh;

    logic                      r_full;
    logic [SUB_W-1:0]          r_res_k;
    logic                      r_res_last;
    logic [OUT_BITS-1:0]       r_res_re, r_res_im;

    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
        localparam longint unsigned PHASE = (64'(g) << 32) / ROM_SIZE;
        assign w_rom[g] = rom_entry(PHASE);
    end

    // tap 0 is the newest sample, older taps sit behind the head
    assign w_diff = {1'b0, r_head} - {1'b0, i_cmd.tap[TW-1:0]};
    assign w_phys = w_diff[TW] ? TW'(w_diff + (TW+1)'(TAPS)) : TW'(w_diff);
    assign w_s32  = {8'h00, i_sample};

    always_ff @(posedge i_clk) begin
        if (i_cmd.hist_clr) begin
            r_hist[i_cmd.clr_addr[TW-1:0]] <= '0;
        end else if (i_cmd.smp_wr) begin
            r_hist[r_wp] <= w_s32[SAMPLE_BITS-1:0];
        end
        r_hist_q <= r_hist[w_phys];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr && i_coef_index < HIST_AW'(TAPS)) begin
            r_win[i_coef_index[TW-1:0]] <= i_coef_value;
        end
        r_win_q <= r_win[i_cmd.tap[TW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r3_v && r3_last && r3_fold) begin
            r_u[r3_n] <= U_BITS'(w_u_sh);
        end
        r_u_q <= r_u[i_cmd.mod_n[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_rom_q <= w_rom[i_cmd.mod_m[MW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_head <= TW'(TAPS - 1);
        end else if (i_cmd.smp_wr) begin
            r_head <= r_wp;
            r_wp   <= (r_wp == TW'(TAPS - 1)) ? '0 : r_wp + TW'(1);
        end
    end

    assign w_op_a = r1_fold ? OP_BITS'(signed'(r_hist_q)) : signed'(r_u_q);
    assign w_op_b = r1_fold ? signed'(r_win_q) : signed'(r_rom_q[2*ROM_BITS-1:ROM_BITS]);
    assign w_pa   = w_op_a * w_op_b;
    assign w_pb   = signed'(r_u_q) * signed'(r_rom_q[ROM_BITS-1:0]);

    assign w_u_sh  = (r_acc_a + U_HALF) >>> (SAMPLE_BITS - 2);
    assign w_re_sh = (r_acc_a + OUT_HALF) >>> OUT_SHIFT;
    assign w_im_sh = (r_acc_b + OUT_HALF) >>> OUT_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_cmd.fold_rd || i_cmd.mod_rd;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_fold  <= i_cmd.fold_rd;
        r1_first <= i_cmd.first;
        r1_last  <= i_cmd.last;
        r1_zero  <= i_cmd.fold_zero;
        r1_n     <= i_cmd.fold_n[NW-1:0];
        r2_fold  <= r1_fold;
        r2_first <= r1_first;
        r2_last  <= r1_last;
        r2_n     <= r1_n;
        r2_pa    <= (r1_fold && r1_zero) ? '0 : w_pa;
        r2_pb    <= w_pb;
        r3_fold  <= r2_fold;
        r3_last  <= r2_last;
        r3_n     <= r2_n;
        if (r2_v) begin
            r_acc_a <= (r2_first ? '0 : r_acc_a) + ACC_BITS'(r2_pa);
            r_acc_b <= (r2_first ? '0 : r_acc_b) + ACC_BITS'(r2_pb);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (r3_v && r3_last && !r3_fold) begin
            r_full <= 1'b1;
        end else if (r_full && i_res_ready) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r3_v && r3_last && !r3_fold) begin
            r_res_re   <= sat_out(w_re_sh);
            r_res_im   <= sat_out(w_im_sh);
            r_res_k    <= i_cmd.k;
            r_res_last <= (i_cmd.k == SUB_W'(SUBBANDS - 1));
        end
    end

    assign o_sts.busy     = r1_v || r2_v || r3_v;
    assign o_sts.res_full = r_full;
    assign o_res_valid    = r_full;
    assign o_subband      = r_res_k;
    assign o_real_part    = signed'(r_res_re);
    assign o_imag_part    = signed'(r_res_im);
    assign o_last         = r_res_last;

endmodule

FILE: tb/sv/tb_complex_qmf_analysis_bank.sv
// self-checking testbench for the complex qmf analysis bank
`timescale 1ns / 1ps
module tb_complex_qmf_analysis_bank;
    import cqmf_pkg::*;

    localparam int NBANDS = 64;
    localparam int NTAPS  = 640;
    localparam int NFOLDS = NTAPS / (2 * NBANDS);
    localparam int PHASES = 8 * NBANDS;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam longint unsigned QONE  = 64'd1073741824;
    localparam longint unsigned QPI_2 = 64'd1686629713;
    localparam longint SAT_HI = 64'sd549755813887;
    localparam longint SAT_LO = -64'sd549755813888;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [SUB_W-1:0]    subband;
        logic [OUT_BITS-1:0] re;
        logic [OUT_BITS-1:0] im;
        logic                last;
    } t_band_val;

    class qmf_scoreboard;
        longint    hist [NTAPS];
        longint    win [NTAPS];
        int        fill;
        longint    cos_tab [PHASES];
        longint    sin_tab [PHASES];
        t_band_val bands_due [$];
        int        mismatches;

        function new();
            longint unsigned p, r, x, ts, tc;
            longint s, c, cm, sm;
            logic [1:0] quad;
            foreach (hist[i]) begin
                hist[i] = 0;
                win[i]  = 0;
            end
            fill = 0;
            mismatches = 0;
            for (int m = 0; m < PHASES; m++) begin
                p    = (longint'(m) << 32) / PHASES;
                quad = p[31:30];
                r    = p & 64'h3FFF_FFFF;
                x    = (r * QPI_2) >> 30;
                s    = longint'(x);
                c    = longint'(QONE);
                ts   = x;
                tc   = QONE;
                for (int i = 1; i <= 9; i++) begin
                    ts = ((((ts * x) >> 30) * x) >> 30) / longint'((2 * i) * (2 * i + 1));
                    tc = ((((tc * x) >> 30) * x) >> 30) / longint'((2 * i - 1) * (2 * i));
                    if (i % 2 == 1) begin
                        s -= longint'(ts);
                        c -= longint'(tc);
                    end else begin
                        s += longint'(ts);
                        c += longint'(tc);
                    end
                end
                cm = q22(c);
                sm = q22(s);
                case (quad)
                    2'd0: begin cos_tab[m] = cm;  sin_tab[m] = sm;  end
                    2'd1: begin cos_tab[m] = -sm; sin_tab[m] = cm;  end
                    2'd2: begin cos_tab[m] = -cm; sin_tab[m] = -sm; end
                    default: begin cos_tab[m] = sm; sin_tab[m] = -cm; end
                endcase
            end
        endfunction

        function longint q22(longint v);
            if (v < 0) v = 0;
            if (v > longint'(QONE)) v = longint'(QONE);
            return (v + 128) >>> 8;
        endfunction

        function logic [OUT_BITS-1:0] round_sat(longint v);
            longint t;
            t = (v + (64'sd1 <<< 21)) >>> 22;
            if (t > SAT_HI) t = SAT_HI;
            if (t < SAT_LO) t = SAT_LO;
            return t[OUT_BITS-1:0];
        endfunction

        function void analyse_block();
            longint    u [2 * NBANDS];
            longint    acc, re, im;
            int        ph;
            t_band_val b;
            for (int n = 0; n < 2 * NBANDS; n++) begin
                acc = 0;
                for (int j = 0; j < NFOLDS; j++)
                    acc += hist[n + j * 2 * NBANDS] * win[n + j * 2 * NBANDS];
                u[n] = (acc + (64'sd1 <<< 21)) >>> 22;
            end
            for (int k = 0; k < NBANDS; k++) begin
                re = 0;
                im = 0;
                for (int n = 0; n < 2 * NBANDS; n++) begin
                    ph = ((2 * k + 1) * (2 * n + PHASES - 1)) % PHASES;
                    re += u[n] * cos_tab[ph];
                    im += u[n] * sin_tab[ph];
                end
                b.subband = k[SUB_W-1:0];
                b.re      = round_sat(re);
                b.im      = round_sat(im);
                b.last    = (k == NBANDS - 1);
                bands_due.insert(bands_due.size(), b);
            end
        endfunction

        function void note(logic [REQ_W-1:0] req, logic signed [SAMPLE_W-1:0] smp,
                           logic [HIST_AW-1:0] idx, logic signed [COEF_BITS-1:0] val);
            case (req)
                REQ_SAMPLE: begin
                    for (int i = NTAPS - 1; i > 0; i--) hist[i] = hist[i-1];
                    hist[0] = longint'(smp);
                    fill++;
                    if (fill == NBANDS) begin
                        fill = 0;
                        analyse_block();
                    end
                end
                REQ_COEF: if (idx < NTAPS) win[idx] = longint'(val);
                REQ_CLEAR: begin
                    foreach (hist[i]) hist[i] = 0;
                    fill = 0;
                end
                default: ;
            endcase
        endfunction

        function void check(logic [SUB_W-1:0] sb, logic [OUT_BITS-1:0] re,
                            logic [OUT_BITS-1:0] im, logic lst);
            t_band_val b;
            if (bands_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: subband %0d re %h im %h last %b",
                             sb, re, im, lst);
                return;
            end
            b = bands_due.pop_front();
            if (b.subband !== sb || b.re !== re || b.im !== im || b.last !== lst) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d %h %h %b, got %0d %h %h %b",
                             b.subband, b.re, b.im, b.last, sb, re, im, lst);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic no_idle;
    int   cycles;
    qmf_scoreboard sb;

    cqmf_in_if  req_if ();
    cqmf_out_if res_if ();

    complex_qmf_analysis_bank dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check(res_if.subband, res_if.real_part, res_if.imag_part, res_if.last);
        res_if.ready <= no_idle || ($urandom_range(99) >= 21);
    end

    task automatic send(logic [REQ_W-1:0] req, logic signed [SAMPLE_W-1:0] smp,
                        logic [HIST_AW-1:0] idx, logic signed [COEF_BITS-1:0] val);
        if (!no_idle && $urandom_range(99) < 21) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        req_if.req_type   <= req;
        req_if.sample     <= smp;
        req_if.coef_index <= idx;
        req_if.coef_value <= val;
        req_if.valid      <= 1'b1;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note(req, smp, idx, val);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2: return 24'h00_0000;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    initial begin
        int r;
        logic [HIST_AW-1:0] idx;
        sb = new();
        cycles = 0;
        no_idle = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_SAMPLE;
        req_if.sample     = '0;
        req_if.coef_index = '0;
        req_if.coef_value = '0;
        res_if.ready      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full window load before any block completes
        for (int i = 0; i < NTAPS; i++)
            send(REQ_COEF, '0, HIST_AW'(i), pick_value());

        // directed corner cases
        send(REQ_COEF, '0, 10'd0, 24'sh7F_FFFF);
        send(REQ_COEF, '0, 10'd639, 24'sh80_0000);
        send(REQ_COEF, '0, 10'd640, 24'sh12_3456);
        send(REQ_COEF, '0, 10'd1023, 24'sh55_AAAA);
        send(REQ_UNUSED, 24'sh7F_FFFF, 10'd1023, 24'sh7F_FFFF);
        for (int i = 0; i < 8; i++)
            send(REQ_SAMPLE, (i % 2) ? 24'sh80_0000 : 24'sh7F_FFFF, '0, '0);
        send(REQ_CLEAR, '0, '0, '0);
        send(REQ_SAMPLE, 24'sh00_0001, '0, '0);
        send(REQ_SAMPLE, 24'shFF_FFFF, '0, '0);
        send(REQ_CLEAR, '0, '0, '0);

        // random traffic, mostly samples so that blocks complete
        for (int n = 0; n < 500; n++) begin
            no_idle = (n >= 150 && n < 250);
            r = $urandom_range(99);
            idx = ($urandom_range(9) == 0) ? HIST_AW'($urandom_range(1023))
                                           : HIST_AW'($urandom_range(NTAPS - 1));
            if (r < 85)
                send(REQ_SAMPLE, pick_value(), HIST_AW'($urandom()), SAMPLE_W'($urandom()));
            else if (r < 93)
                send(REQ_COEF, SAMPLE_W'($urandom()), idx, pick_value());
            else if (r < 97)
                send(REQ_CLEAR, SAMPLE_W'($urandom()), HIST_AW'($urandom()), '0);
            else
                send(REQ_UNUSED, pick_value(), HIST_AW'($urandom()), pick_value());
        end
        no_idle = 1'b0;
        req_if.valid <= 1'b0;

        while (sb.bands_due.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.bands_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
